>>> rtl/ntfs_drd_pkg.sv
// Shared types and constants for the NTFS data-run list decoder.
package ntfs_drd_pkg;

  localparam int unsigned RECORD_BYTES = 1024;
  localparam int unsigned RECORD_LOG2  = $clog2(RECORD_BYTES);

  localparam logic [7:0]  BYTE_MASK  = 8'hFF;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_RUN       = 2'd0,
    KIND_SPARSE    = 2'd1,
    KIND_END       = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_e;

  // One decoded event handed from the byte parser to the scaling stage.
  typedef struct packed {
    kind_e             kind;
    logic [63:0]       run_clusters;
    logic signed [63:0] start_cluster;
  } run_t;

endpackage

>>> rtl/ntfs_drd_parser.sv
// Byte-level parser of a data-run list: headers, length and offset fields, cluster sum.
module ntfs_drd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          run_byte_i,
  input  logic                list_start_i,
  output logic                run_valid_o,
  input  logic                run_ready_i,
  output ntfs_drd_pkg::run_t  run_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [3:0]         len_size_q, len_size_d;
  logic [3:0]         off_size_q, off_size_d;
  logic [3:0]         idx_q, idx_d;
  logic [63:0]        len_acc_q, len_acc_d;
  logic [63:0]        off_acc_q, off_acc_d;
  logic [63:0]        clus_acc_q, clus_acc_d;
  logic               run_valid_q, run_valid_d;
  ntfs_drd_pkg::run_t run_q, run_d;

  logic               accept;
  phase_e             phase_eff;
  logic [63:0]        clus_eff;
  logic [63:0]        byte_placed;
  logic [63:0]        len_new;
  logic [63:0]        off_new;
  logic [63:0]        off_ext;
  logic [3:0]         idx_inc;
  logic [5:0]         sign_pos;
  logic [6:0]         ext_shift;
  logic [63:0]        clus_sum;
  logic [3:0]         hdr_len;
  logic [3:0]         hdr_off;

  assign in_ready_o  = !run_valid_q || run_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign run_valid_o = run_valid_q;
  assign run_o       = run_q;

  always_comb begin
    phase_eff   = list_start_i ? PH_HEADER : phase_q;
    clus_eff    = list_start_i ? 64'd0 : clus_acc_q;
    byte_placed = {56'd0, run_byte_i & ntfs_drd_pkg::BYTE_MASK} << {idx_q[2:0], 3'b000};
    len_new     = len_acc_q | byte_placed;
    off_new     = off_acc_q | byte_placed;
    idx_inc     = idx_q + 4'd1;
    hdr_len     = run_byte_i[3:0];
    hdr_off     = run_byte_i[7:4];
    // Sign-extend the offset field from its top received byte.
    ext_shift   = {off_size_q, 3'b000};
    sign_pos    = 6'(ext_shift - 7'd1);
    off_ext     = off_new;
    if (off_size_q < 4'd8 && off_new[sign_pos]) begin
      off_ext = off_new | (ntfs_drd_pkg::ALL_ONES << ext_shift);
    end
    clus_sum    = clus_eff + off_ext;
  end

  always_comb begin
    phase_d     = phase_q;
    len_size_d  = len_size_q;
    off_size_d  = off_size_q;
    idx_d       = idx_q;
    len_acc_d   = len_acc_q;
    off_acc_d   = off_acc_q;
    clus_acc_d  = clus_acc_q;
    run_valid_d = run_valid_q && !run_ready_i;
    run_d       = run_q;
    if (accept) begin
      clus_acc_d = clus_eff;
      idx_d      = list_start_i ? 4'd0 : idx_q;
      phase_d    = phase_eff;
      case (phase_eff)
        PH_LENGTH: begin
          len_acc_d = len_new;
          idx_d     = idx_inc;
          if (idx_inc >= len_size_q) begin
            idx_d = 4'd0;
            if (off_size_q == 4'd0) begin
              phase_d                 = PH_HEADER;
              run_valid_d             = 1'b1;
              run_d.kind              = ntfs_drd_pkg::KIND_SPARSE;
              run_d.run_clusters      = len_new;
              run_d.start_cluster     = 64'sd0;
            end else begin
              phase_d = PH_OFFSET;
            end
          end
        end
        PH_OFFSET: begin
          off_acc_d = off_new;
          idx_d     = idx_inc;
          if (idx_inc >= off_size_q) begin
            phase_d             = PH_HEADER;
            idx_d               = 4'd0;
            clus_acc_d          = clus_sum;
            run_valid_d         = 1'b1;
            run_d.kind          = ntfs_drd_pkg::KIND_RUN;
            run_d.run_clusters  = len_acc_q;
            run_d.start_cluster = $signed(clus_sum);
          end
        end
        default: begin
          if (hdr_len == 4'd0 || hdr_len > 4'd8 || hdr_off > 4'd8) begin
            run_valid_d         = 1'b1;
            run_d.kind          = (hdr_len == 4'd0) ? ntfs_drd_pkg::KIND_END
                                                    : ntfs_drd_pkg::KIND_MALFORMED;
            run_d.run_clusters  = 64'd0;
            run_d.start_cluster = 64'sd0;
          end else begin
            len_size_d = hdr_len;
            off_size_d = hdr_off;
            idx_d      = 4'd0;
            len_acc_d  = 64'd0;
            off_acc_d  = 64'd0;
            phase_d    = PH_LENGTH;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      len_size_q  <= 4'd0;
      off_size_q  <= 4'd0;
      idx_q       <= 4'd0;
      len_acc_q   <= 64'd0;
      off_acc_q   <= 64'd0;
      clus_acc_q  <= 64'd0;
      run_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_size_q  <= len_size_d;
      off_size_q  <= off_size_d;
      idx_q       <= idx_d;
      len_acc_q   <= len_acc_d;
      off_acc_q   <= off_acc_d;
      clus_acc_q  <= clus_acc_d;
      run_valid_q <= run_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

endmodule

>>> rtl/ntfs_drd_scale.sv
// Converts clusters to bytes and records with saturating shifts, and holds the result register.
module ntfs_drd_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          cluster_shift_i,
  input  logic                run_valid_i,
  output logic                run_ready_o,
  input  ntfs_drd_pkg::run_t  run_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [63:0]         run_clusters_o,
  output logic [63:0]         start_cluster_o,
  output logic [63:0]         start_byte_o,
  output logic [63:0]         record_count_o
);

  localparam logic [4:0] RecLog2 = 5'(ntfs_drd_pkg::RECORD_LOG2);

  function automatic logic [63:0] shl_sat(input logic [63:0] v, input logic [4:0] s);
    logic [63:0] shifted;
    begin
      shifted = v << s;
      shl_sat = ((shifted >> s) != v) ? ntfs_drd_pkg::ALL_ONES : shifted;
    end
  endfunction

  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [63:0] clusters_q, start_q, sbyte_q, recs_q;
  logic        load;
  logic [63:0] sbyte_d, recs_d;

  assign run_ready_o = !out_valid_q || out_ready_i;
  assign load        = run_valid_i && run_ready_o;

  always_comb begin
    sbyte_d = run_i.start_cluster[63] ? 64'd0
                                      : shl_sat(run_i.start_cluster, cluster_shift_i);
    // Records are whole when the cluster is at least one record, else a right shift.
    if (cluster_shift_i >= RecLog2) begin
      recs_d = shl_sat(run_i.run_clusters, cluster_shift_i - RecLog2);
    end else begin
      recs_d = run_i.run_clusters >> (RecLog2 - cluster_shift_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (run_ready_o) begin
      out_valid_q <= run_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q     <= run_i.kind;
      clusters_q <= run_i.run_clusters;
      start_q    <= run_i.start_cluster;
      sbyte_q    <= sbyte_d;
      recs_q     <= recs_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign run_clusters_o  = clusters_q;
  assign start_cluster_o = start_q;
  assign start_byte_o    = sbyte_q;
  assign record_count_o  = recs_q;

endmodule

>>> rtl/ntfs_data_run_decoder.sv
// NTFS data-run list decoder: one list byte per request, one result per finished run,
// end marker or malformed header; a result is held in the parser register, then the result
// register. Throughput: one byte per cycle until both registers hold results and the
// output stalls; the two form an elastic two-stage pipeline.
// Reset: phase, sizes, accumulators and valids clear; cluster_shift returns to 12.
module ntfs_data_run_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i,     // cluster_shift
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] run_byte
  input  logic [0:0]   s_axis_tuser,   // [0] list_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] run_clusters, [127:64] start_cluster, [191:128] start_byte,
  // [255:192] record_count
  output logic [255:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // [1:0] kind
);

  logic [4:0]         shift_q;
  logic               run_valid, run_ready;
  ntfs_drd_pkg::run_t run;
  logic [63:0]        clusters, start, sbyte, recs;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 5'd12;
    end else if (cfg_valid_i) begin
      shift_q <= cfg_data_i;
    end
  end

  ntfs_drd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .run_byte_i   (s_axis_tdata),
    .list_start_i (s_axis_tuser[0]),
    .run_valid_o  (run_valid),
    .run_ready_i  (run_ready),
    .run_o        (run)
  );

  ntfs_drd_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cluster_shift_i (shift_q),
    .run_valid_i     (run_valid),
    .run_ready_o     (run_ready),
    .run_i           (run),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .kind_o          (m_axis_tuser),
    .run_clusters_o  (clusters),
    .start_cluster_o (start),
    .start_byte_o    (sbyte),
    .record_count_o  (recs)
  );

  assign m_axis_tdata = {recs, sbyte, start, clusters};

endmodule

>>> rtl/ntfs_drd_checker.sv
// Port-level checks for the NTFS data-run list decoder, bound to the top level.
module ntfs_drd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ntfs_drd_pkg::KIND_END ||
                      m_axis_tuser == ntfs_drd_pkg::KIND_MALFORMED)
    |-> m_axis_tdata == 256'd0)
    else $error("end or malformed result carries data");

  a_nostart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ntfs_drd_pkg::KIND_SPARSE || m_axis_tdata[127])
    |-> m_axis_tdata[191:128] == 64'd0)
    else $error("start byte set for sparse or negative start");

  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a request");

endmodule

bind ntfs_data_run_decoder ntfs_drd_checker u_checker (.*);
